@@ design/mexu_pkg.sv @@
// ----------------------------------------------------------------------------
// mexu_pkg
// Shared types and constants of the COP0 exception entry unit.
// ----------------------------------------------------------------------------
package mexu_pkg;

    // Exception vectors.
    localparam logic [31:0] VEC_GENERAL = 32'h8000_0180;
    localparam logic [31:0] VEC_REFILL  = 32'h8000_0000;

    // Context and EntryHi masks.
    localparam logic [31:0] CTX_KEEP = 32'hFF80_000F;
    localparam logic [31:0] CTX_VPN  = 32'h007F_FFF0;
    localparam logic [31:0] HI_VPN   = 32'hFFFF_E000;

    // Cause fields.
    localparam logic [31:0] CAUSE_DELAY_SLOT = 32'h8000_0000;
    localparam logic [31:0] CE_ONE           = 32'h1000_0000;

    // ExcCode values, already placed at Cause bits 6..2.
    localparam logic [31:0] EXC_INT  = 32'd0;
    localparam logic [31:0] EXC_TLBL = 32'd8;
    localparam logic [31:0] EXC_ADEL = 32'd16;
    localparam logic [31:0] EXC_ADES = 32'd20;
    localparam logic [31:0] EXC_SYS  = 32'd32;
    localparam logic [31:0] EXC_BP   = 32'd36;
    localparam logic [31:0] EXC_CPU  = 32'd44;

    // Status bit positions.
    localparam int ST_IE  = 0;
    localparam int ST_EXL = 1;
    localparam int ST_ERL = 2;

    // MI audio bit and pending IP2 bit positions.
    localparam int MI_AUDIO = 2;
    localparam int IP2_BIT  = 2;

    localparam int IN_TDATA_W  = 120;
    localparam int OUT_TDATA_W = 232;

    typedef enum logic [2:0] {
        ACT_CHECK     = 3'd0,
        ACT_ADDR_ERR  = 3'd1,
        ACT_BREAK     = 3'd2,
        ACT_COP_UNUSE = 3'd3,
        ACT_INTERRUPT = 3'd4,
        ACT_TLB_MISS  = 3'd5,
        ACT_SYSCALL   = 3'd6,
        ACT_WR_STATUS = 3'd7
    } t_action;

    // One event, as held in the input register.
    typedef struct packed {
        t_action     action;
        logic        delay_slot;
        logic        from_read;
        logic [31:0] bad_vaddr;
        logic        cop_is_one;
        logic [31:0] cur_pc;
        logic        tlb_defined;
        logic [5:0]  mi_pending;
        logic [5:0]  mi_enable;
        logic        audio_irq;
        logic [31:0] status_data;
    } t_event;

    // One result, as held in the output register.
    typedef struct packed {
        logic [5:0]  mi_merged;
        logic [31:0] entryhi_out;
        logic [31:0] context_out;
        logic [31:0] badvaddr_out;
        logic [31:0] epc_out;
        logic [31:0] status_out;
        logic [31:0] cause_out;
        logic        want_interrupt;
        logic        taken;
        logic [31:0] next_pc;
    } t_result;

endpackage

@@ design/mips_exception_entry_unit.sv @@
// ----------------------------------------------------------------------------
// mips_exception_entry_unit
// COP0 exception entry: keeps Status, Cause, EPC, BadVAddr, Context, EntryHi
// and the pending IP2 bit, and computes the new PC for each event.
//
// Each event transaction on the slave stream produces exactly one result
// transaction on the master stream. The unit has an input register and a
// result register with one level of bit logic between them, so it takes one
// event per clock cycle while the master side does not stall, and each result
// is presented on the master side once its event has moved on into the result
// register. The COP0 registers are updated when an event moves from the input
// register into the result register, so the next event already sees them.
// Back-pressure on the master side stalls the result register first; the input
// register keeps accepting until both are full. The audio merge configuration
// bit may only be written while no event is in flight.
// ----------------------------------------------------------------------------
module mips_exception_entry_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration: bit 0 is audio_merge_off.
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data,
    // Event stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata from bit 0 up: delay_slot, from_read, bad_vaddr[31:0], cop_is_one,
    // cur_pc[31:0], tlb_defined, mi_pending[5:0], mi_enable[5:0], audio_irq,
    // status_data[31:0], then zero padding to bit 119.
    input  logic [mexu_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tuser from bit 0 up: action[2:0].
    input  logic [2:0]                          s_axis_tuser,
    // Result stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata from bit 0 up: next_pc[31:0], taken, want_interrupt,
    // cause_out[31:0], status_out[31:0], epc_out[31:0], badvaddr_out[31:0],
    // context_out[31:0], entryhi_out[31:0], mi_merged[5:0].
    output logic [mexu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import mexu_pkg::*;

    // Pipeline registers.
    logic    r_s1_valid;
    t_event  r_s1;
    logic    r_out_valid;
    t_result r_out;

    // Architectural state.
    logic        r_audio_merge_off;
    logic [31:0] r_status, n_status;
    logic [31:0] r_cause, n_cause;
    logic [31:0] r_epc, n_epc;
    logic [31:0] r_badvaddr, n_badvaddr;
    logic [31:0] r_context, n_context;
    logic [31:0] r_entryhi, n_entryhi;
    logic [7:0]  r_pending_ip, n_pending_ip;

    logic        advance;
    logic [5:0]  merged;
    logic        int_enabled;
    logic [31:0] exc_code;
    logic [31:0] enter_cause;
    logic [31:0] enter_epc;
    logic [31:0] next_pc;
    logic        taken;
    logic        want;

    // The result register frees up when it is empty or being taken, and the
    // input register moves forward whenever the result register can load.
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // Audio merge is computed for every action.
    always_comb begin
        merged = r_s1.mi_pending;
        if (!r_audio_merge_off) begin
            merged[MI_AUDIO] = r_s1.audio_irq;
        end
    end

    assign int_enabled = r_status[ST_IE] && !r_status[ST_EXL] && !r_status[ST_ERL];

    // Exception code for the actions that go through the common entry path.
    always_comb begin
        case (r_s1.action)
            ACT_ADDR_ERR:  exc_code = r_s1.from_read ? EXC_ADEL : EXC_ADES;
            ACT_BREAK:     exc_code = EXC_BP;
            ACT_COP_UNUSE: exc_code = EXC_CPU | (r_s1.cop_is_one ? CE_ONE : 32'd0);
            ACT_INTERRUPT: exc_code = {16'd0, r_pending_ip, 8'd0} | EXC_INT;
            ACT_SYSCALL:   exc_code = EXC_SYS;
            default:       exc_code = EXC_TLBL;
        endcase
    end

    // A delay slot sets BD and points EPC at the branch, four bytes back.
    assign enter_cause = exc_code | (r_s1.delay_slot ? CAUSE_DELAY_SLOT : 32'd0);
    assign enter_epc   = r_s1.delay_slot ? (r_s1.cur_pc - 32'd4) : r_s1.cur_pc;

    always_comb begin
        n_status     = r_status;
        n_cause      = r_cause;
        n_epc        = r_epc;
        n_badvaddr   = r_badvaddr;
        n_context    = r_context;
        n_entryhi    = r_entryhi;
        n_pending_ip = r_pending_ip;
        next_pc      = r_s1.cur_pc;
        taken        = 1'b0;
        want         = 1'b0;
        unique case (r_s1.action) inside
            ACT_CHECK: begin
                // Refresh IP2 first; the enable test sees the new value.
                n_pending_ip[IP2_BIT] = |(r_s1.mi_enable & merged);
                want = int_enabled && (|(r_status[15:8] & n_pending_ip));
            end
            ACT_ADDR_ERR, ACT_BREAK, ACT_COP_UNUSE, ACT_SYSCALL: begin
                // These are entered even with EXL or ERL already set.
                if (r_s1.action == ACT_ADDR_ERR) begin
                    n_badvaddr = r_s1.bad_vaddr;
                end
                n_cause          = enter_cause;
                n_epc            = enter_epc;
                n_status[ST_EXL] = 1'b1;
                next_pc          = VEC_GENERAL;
                taken            = 1'b1;
            end
            ACT_INTERRUPT: begin
                if (int_enabled) begin
                    n_cause          = enter_cause;
                    n_epc            = enter_epc;
                    n_status[ST_EXL] = 1'b1;
                    next_pc          = VEC_GENERAL;
                    taken            = 1'b1;
                end
            end
            ACT_TLB_MISS: begin
                // Store misses are reported as load misses as well.
                n_badvaddr = r_s1.bad_vaddr;
                n_context  = (r_context & CTX_KEEP) | ({9'd0, r_s1.bad_vaddr[31:9]} & CTX_VPN);
                n_entryhi  = r_s1.bad_vaddr & HI_VPN;
                taken      = 1'b1;
                if (!r_status[ST_EXL]) begin
                    n_cause          = enter_cause;
                    n_epc            = enter_epc;
                    n_status[ST_EXL] = 1'b1;
                    next_pc          = r_s1.tlb_defined ? VEC_GENERAL : VEC_REFILL;
                end else begin
                    // Nested miss: no BD, EPC and Status kept, general vector.
                    n_cause = EXC_TLBL;
                    next_pc = VEC_GENERAL;
                end
            end
            ACT_WR_STATUS: begin
                n_status = r_s1.status_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_audio_merge_off <= 1'b0;
            r_status          <= '0;
            r_cause           <= '0;
            r_epc             <= '0;
            r_badvaddr        <= '0;
            r_context         <= '0;
            r_entryhi         <= '0;
            r_pending_ip      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_audio_merge_off <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid) begin
                    r_status     <= n_status;
                    r_cause      <= n_cause;
                    r_epc        <= n_epc;
                    r_badvaddr   <= n_badvaddr;
                    r_context    <= n_context;
                    r_entryhi    <= n_entryhi;
                    r_pending_ip <= n_pending_ip;
                end
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_s1.action      <= t_action'(s_axis_tuser);
            r_s1.delay_slot  <= s_axis_tdata[0];
            r_s1.from_read   <= s_axis_tdata[1];
            r_s1.bad_vaddr   <= s_axis_tdata[33:2];
            r_s1.cop_is_one  <= s_axis_tdata[34];
            r_s1.cur_pc      <= s_axis_tdata[66:35];
            r_s1.tlb_defined <= s_axis_tdata[67];
            r_s1.mi_pending  <= s_axis_tdata[73:68];
            r_s1.mi_enable   <= s_axis_tdata[79:74];
            r_s1.audio_irq   <= s_axis_tdata[80];
            r_s1.status_data <= s_axis_tdata[112:81];
        end
        if (advance && r_s1_valid) begin
            r_out.next_pc        <= next_pc;
            r_out.taken          <= taken;
            r_out.want_interrupt <= want;
            r_out.cause_out      <= n_cause;
            r_out.status_out     <= n_status;
            r_out.epc_out        <= n_epc;
            r_out.badvaddr_out   <= n_badvaddr;
            r_out.context_out    <= n_context;
            r_out.entryhi_out    <= n_entryhi;
            r_out.mi_merged      <= merged;
        end
    end

    // A taken exception always lands on one of the two vectors.
    a_taken_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.taken) |->
            (r_out.next_pc == VEC_GENERAL || r_out.next_pc == VEC_REFILL))
        else $error("taken exception without a vector PC");

    // Only the interrupt check reports a wanted interrupt, and it never redirects.
    a_want_not_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.want_interrupt) |-> !r_out.taken)
        else $error("wanted interrupt together with a taken exception");

    // Every exception entry leaves EXL set.
    a_taken_exl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.taken) |-> r_out.status_out[ST_EXL])
        else $error("exception taken with EXL clear");

    // A stalled event stays in the input register untouched.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1)))
        else $error("input register lost a stalled event");

    // The result register mirrors the state registers it was loaded with.
    a_state_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.status_out == r_status && r_out.cause_out == r_cause))
        else $error("result register out of step with COP0 state");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the COP0 exception entry unit. Event transactions
// are driven on the slave stream, the expected result of each one is worked
// out by a local predictor of the COP0 registers, and every result
// transaction is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module testbench;
    import mexu_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    // The unit has two register stages, so a few quiet cycles are plenty to be
    // sure that nothing is left in flight.
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_EVENTS  = 290;
    localparam int MAX_REPORTS   = 200;

    // What the sender has lined up: an event, a write of the audio merge bit,
    // or a pause until every outstanding result has come back.
    typedef enum logic [1:0] {
        ITEM_EVENT,
        ITEM_CONFIG,
        ITEM_DRAIN
    } t_item_kind;

    typedef struct {
        t_item_kind kind;
        t_event     ev;
        logic       cfg_value;
    } t_pending;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_data = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // tdata from bit 0 up: delay_slot, from_read, bad_vaddr, cop_is_one,
    // cur_pc, tlb_defined, mi_pending, mi_enable, audio_irq, status_data.
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // tuser from bit 0 up: action.
    logic [2:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // tdata from bit 0 up: next_pc, taken, want_interrupt, cause_out,
    // status_out, epc_out, badvaddr_out, context_out, entryhi_out, mi_merged.
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Local copy of the COP0 state and of the configuration bit.
    logic [31:0] cop0_status   = '0;
    logic [31:0] cop0_cause    = '0;
    logic [31:0] cop0_epc      = '0;
    logic [31:0] cop0_badvaddr = '0;
    logic [31:0] cop0_context  = '0;
    logic [31:0] cop0_entryhi  = '0;
    logic [7:0]  cop0_ip       = '0;
    logic        audio_merge_off = 1'b0;

    t_pending    pending_items[$];
    t_result     expected_results[$];
    t_event      driven_event;

    // Handshake flags raised at the rising edge and consumed by the drivers at
    // the following falling edge.
    bit          ev_taken  = 1'b0;
    bit          cfg_taken = 1'b0;
    logic        next_tvalid;
    logic        next_cfg_valid;
    int          tx_gap = 0;
    int          tx_calm = 0;
    int          rx_stall = 0;
    int          rx_calm = 0;
    int          idle_cycles = 0;
    int          queued_events = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    mips_exception_entry_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // COP0 predictor
    // ------------------------------------------------------------------------

    function automatic logic irq_enabled();
        return cop0_status[ST_IE] && !cop0_status[ST_EXL] && !cop0_status[ST_ERL];
    endfunction

    // Exception entry proper: Cause is overwritten as a whole, EPC points at
    // the branch when the faulting instruction sits in its delay slot, and
    // Status.EXL is raised.
    function automatic logic [31:0] enter_exception(logic [31:0] code, logic ds,
                                                    logic [31:0] pc);
        cop0_cause = code;
        if (ds) begin
            cop0_cause = cop0_cause | CAUSE_DELAY_SLOT;
            cop0_epc   = pc - 32'd4;
        end else begin
            cop0_epc = pc;
        end
        cop0_status[ST_EXL] = 1'b1;
        return VEC_GENERAL;
    endfunction

    // Applies one event to the local COP0 state and returns the result that
    // the unit must produce for it.
    function automatic t_result predict_cop0(t_event ev);
        t_result    r;
        logic [5:0] merged;
        r = '0;
        r.next_pc = ev.cur_pc;
        merged = ev.mi_pending;
        if (!audio_merge_off) begin
            merged[MI_AUDIO] = ev.audio_irq;
        end
        case (ev.action)
            ACT_CHECK: begin
                cop0_ip[IP2_BIT] = |(ev.mi_enable & merged);
                r.want_interrupt = irq_enabled() && |(cop0_status[15:8] & cop0_ip);
            end
            ACT_ADDR_ERR: begin
                cop0_badvaddr = ev.bad_vaddr;
                r.next_pc = enter_exception(ev.from_read ? EXC_ADEL : EXC_ADES,
                                            ev.delay_slot, ev.cur_pc);
                r.taken = 1'b1;
            end
            ACT_BREAK: begin
                r.next_pc = enter_exception(EXC_BP, ev.delay_slot, ev.cur_pc);
                r.taken = 1'b1;
            end
            ACT_COP_UNUSE: begin
                r.next_pc = enter_exception(EXC_CPU | (ev.cop_is_one ? CE_ONE : 32'd0),
                                            ev.delay_slot, ev.cur_pc);
                r.taken = 1'b1;
            end
            ACT_INTERRUPT: begin
                // A masked interrupt leaves everything as it was.
                if (irq_enabled()) begin
                    r.next_pc = enter_exception({16'd0, cop0_ip, 8'd0} | EXC_INT,
                                                ev.delay_slot, ev.cur_pc);
                    r.taken = 1'b1;
                end
            end
            ACT_TLB_MISS: begin
                // Store misses are coded as load misses too.
                cop0_cause    = EXC_TLBL;
                cop0_badvaddr = ev.bad_vaddr;
                cop0_context  = (cop0_context & CTX_KEEP) | ((ev.bad_vaddr >> 9) & CTX_VPN);
                cop0_entryhi  = ev.bad_vaddr & HI_VPN;
                if (!cop0_status[ST_EXL]) begin
                    void'(enter_exception(EXC_TLBL, ev.delay_slot, ev.cur_pc));
                    r.next_pc = ev.tlb_defined ? VEC_GENERAL : VEC_REFILL;
                end else begin
                    // Nested miss: EPC and Status are kept, BD stays clear.
                    r.next_pc = VEC_GENERAL;
                end
                r.taken = 1'b1;
            end
            ACT_SYSCALL: begin
                r.next_pc = enter_exception(EXC_SYS, ev.delay_slot, ev.cur_pc);
                r.taken = 1'b1;
            end
            default: begin
                cop0_status = ev.status_data;
            end
        endcase
        r.cause_out    = cop0_cause;
        r.status_out   = cop0_status;
        r.epc_out      = cop0_epc;
        r.badvaddr_out = cop0_badvaddr;
        r.context_out  = cop0_context;
        r.entryhi_out  = cop0_entryhi;
        r.mi_merged    = merged;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic logic [IN_TDATA_W-1:0] pack_event(t_event ev);
        // 113 bits of fields, padded with zeros up to the next whole byte.
        return {7'd0, ev.status_data, ev.audio_irq, ev.mi_enable, ev.mi_pending,
                ev.tlb_defined, ev.cur_pc, ev.cop_is_one, ev.bad_vaddr,
                ev.from_read, ev.delay_slot};
    endfunction

    // Random event content. Status values lean toward interrupts enabled with
    // EXL and ERL clear, otherwise interrupt entry would hardly ever happen.
    function automatic t_event gen_event(t_action act);
        t_event ev;
        ev.action      = act;
        ev.delay_slot  = 1'($urandom);
        ev.from_read   = 1'($urandom);
        ev.bad_vaddr   = $urandom;
        ev.cop_is_one  = 1'($urandom);
        ev.cur_pc      = $urandom;
        ev.tlb_defined = 1'($urandom);
        ev.mi_pending  = 6'($urandom);
        ev.mi_enable   = ($urandom_range(0, 5) == 0) ? 6'd0 : 6'($urandom);
        ev.audio_irq   = 1'($urandom);
        ev.status_data = $urandom;
        if ($urandom_range(0, 3) != 0) begin
            ev.status_data[ST_IE]  = 1'b1;
            ev.status_data[ST_EXL] = 1'b0;
            ev.status_data[ST_ERL] = 1'b0;
        end
        return ev;
    endfunction

    function automatic t_action rand_action();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 6)  return ACT_CHECK;
        if (pick < 10) return ACT_WR_STATUS;
        if (pick < 12) return ACT_INTERRUPT;
        if (pick < 14) return ACT_TLB_MISS;
        if (pick < 15) return ACT_ADDR_ERR;
        if (pick < 16) return ACT_BREAK;
        if (pick < 17) return ACT_COP_UNUSE;
        if (pick < 18) return ACT_SYSCALL;
        return ACT_CHECK;
    endfunction

    // Idle length for either side: mostly none or short, now and then long,
    // and from time to time a calm stretch with no idling at all.
    function automatic int idle_gap(ref int calm);
        int pick;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 63) == 0) begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic push_event(t_event ev);
        t_pending p;
        p.kind      = ITEM_EVENT;
        p.ev        = ev;
        p.cfg_value = 1'b0;
        pending_items.push_back(p);
        queued_events++;
    endtask

    task automatic push_control(t_item_kind kind, logic value);
        t_pending p;
        p.kind      = kind;
        p.ev        = '0;
        p.cfg_value = value;
        pending_items.push_back(p);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            if (mismatches < MAX_REPORTS) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            end
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sender: drives events and configuration writes at the falling edge.
    // The next valid level of each channel is settled in a variable first so
    // that every output gets exactly one assignment per edge; a transaction
    // followed by one without a gap thus keeps tvalid high.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        next_tvalid    = s_axis_tvalid;
        next_cfg_valid = i_cfg_valid;
        if (ev_taken) begin
            ev_taken    = 1'b0;
            next_tvalid = 1'b0;
        end
        if (cfg_taken) begin
            cfg_taken      = 1'b0;
            next_cfg_valid = 1'b0;
        end
        if (i_rst_n && !next_tvalid && !next_cfg_valid && pending_items.size() != 0) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (pending_items[0].kind == ITEM_EVENT) begin
                driven_event = pending_items[0].ev;
                s_axis_tdata <= pack_event(driven_event);
                s_axis_tuser <= driven_event.action;
                next_tvalid  = 1'b1;
                void'(pending_items.pop_front());
                tx_gap = idle_gap(tx_calm);
            end else if (expected_results.size() != 0) begin
                // Configuration writes and drain points wait for the unit to
                // run empty.
                idle_cycles = 0;
            end else if (idle_cycles < SETTLE_CYCLES) begin
                idle_cycles++;
            end else begin
                idle_cycles = 0;
                if (pending_items[0].kind == ITEM_CONFIG) begin
                    i_cfg_data     <= pending_items[0].cfg_value;
                    next_cfg_valid = 1'b1;
                end
                void'(pending_items.pop_front());
            end
        end
        s_axis_tvalid <= next_tvalid;
        i_cfg_valid   <= next_cfg_valid;
    end

    // Receiver: random back-pressure on the result stream.
    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            rx_stall = idle_gap(rx_calm);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: samples every handshake at the rising edge. Results are checked
    // before a new event is predicted, so a result can never be matched with
    // the expectation of an event accepted at the same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata);
                if (expected_results.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $error("result transaction with no event outstanding");
                    end
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("next_pc", want.next_pc, got.next_pc);
                    check_field("taken", 32'(want.taken), 32'(got.taken));
                    check_field("want_interrupt", 32'(want.want_interrupt),
                                32'(got.want_interrupt));
                    check_field("cause_out", want.cause_out, got.cause_out);
                    check_field("status_out", want.status_out, got.status_out);
                    check_field("epc_out", want.epc_out, got.epc_out);
                    check_field("badvaddr_out", want.badvaddr_out, got.badvaddr_out);
                    check_field("context_out", want.context_out, got.context_out);
                    check_field("entryhi_out", want.entryhi_out, got.entryhi_out);
                    check_field("mi_merged", 32'(want.mi_merged), 32'(got.mi_merged));
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_cop0(driven_event));
                ev_taken = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                audio_merge_off = i_cfg_data;
                cfg_taken = 1'b1;
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_event ev;
        int     phase_end;
        bit     drained;

        // Directed part, with the audio merge active.
        push_control(ITEM_CONFIG, 1'b0);

        // Quiet check out of reset: nothing pending, nothing wanted.
        ev = gen_event(ACT_CHECK);
        ev.mi_pending = 6'd0;
        ev.mi_enable  = 6'd0;
        ev.audio_irq  = 1'b0;
        push_event(ev);
        // Enable interrupts with every IM bit open.
        ev = gen_event(ACT_WR_STATUS);
        ev.status_data = 32'h0000_FF01;
        push_event(ev);
        // The audio request alone raises IP2 through the merge.
        ev = gen_event(ACT_CHECK);
        ev.mi_pending = 6'd0;
        ev.mi_enable  = 6'h3F;
        ev.audio_irq  = 1'b1;
        push_event(ev);
        // All pending but the merged audio bit, and only audio enabled.
        ev = gen_event(ACT_CHECK);
        ev.mi_pending = 6'h3F;
        ev.mi_enable  = 6'h04;
        ev.audio_irq  = 1'b0;
        push_event(ev);
        ev = gen_event(ACT_CHECK);
        ev.mi_pending = 6'h04;
        ev.mi_enable  = 6'h3F;
        ev.audio_irq  = 1'b1;
        push_event(ev);
        // Interrupt entry from a delay slot at PC zero: EPC wraps around.
        ev = gen_event(ACT_INTERRUPT);
        ev.delay_slot = 1'b1;
        ev.cur_pc     = 32'h0000_0000;
        push_event(ev);
        // EXL is now set, so a second interrupt is ignored.
        push_event(gen_event(ACT_INTERRUPT));
        // Address errors are entered even with EXL set.
        ev = gen_event(ACT_ADDR_ERR);
        ev.from_read  = 1'b1;
        ev.delay_slot = 1'b0;
        ev.bad_vaddr  = 32'hFFFF_FFFF;
        ev.cur_pc     = 32'hFFFF_FFFF;
        push_event(ev);
        ev = gen_event(ACT_ADDR_ERR);
        ev.from_read  = 1'b0;
        ev.delay_slot = 1'b1;
        ev.bad_vaddr  = 32'h0000_0000;
        push_event(ev);
        ev = gen_event(ACT_BREAK);
        ev.delay_slot = 1'b0;
        push_event(ev);
        ev = gen_event(ACT_COP_UNUSE);
        ev.cop_is_one = 1'b1;
        push_event(ev);
        ev = gen_event(ACT_COP_UNUSE);
        ev.cop_is_one = 1'b0;
        ev.delay_slot = 1'b1;
        push_event(ev);
        push_event(gen_event(ACT_SYSCALL));
        // Nested TLB miss: EPC and Status stay, general vector.
        ev = gen_event(ACT_TLB_MISS);
        ev.delay_slot  = 1'b1;
        ev.tlb_defined = 1'b0;
        ev.bad_vaddr   = 32'hFFFF_FFFF;
        push_event(ev);
        // A fresh store miss with no TLB entry goes to the refill vector.
        ev = gen_event(ACT_WR_STATUS);
        ev.status_data = 32'h0000_0000;
        push_event(ev);
        ev = gen_event(ACT_TLB_MISS);
        ev.from_read   = 1'b0;
        ev.tlb_defined = 1'b0;
        ev.bad_vaddr   = 32'hFFFF_FFFF;
        push_event(ev);
        ev = gen_event(ACT_WR_STATUS);
        ev.status_data = 32'h0000_0000;
        push_event(ev);
        ev = gen_event(ACT_TLB_MISS);
        ev.tlb_defined = 1'b1;
        ev.delay_slot  = 1'b1;
        ev.bad_vaddr   = 32'h0000_0000;
        push_event(ev);
        // ERL masks both interrupt entry and the check result.
        ev = gen_event(ACT_WR_STATUS);
        ev.status_data = 32'h0000_FF05;
        push_event(ev);
        push_event(gen_event(ACT_INTERRUPT));
        ev = gen_event(ACT_CHECK);
        ev.mi_pending = 6'h3F;
        ev.mi_enable  = 6'h3F;
        push_event(ev);
        ev = gen_event(ACT_WR_STATUS);
        ev.status_data = 32'hFFFF_FFFF;
        push_event(ev);
        // IE clear: interrupt entry is refused.
        ev = gen_event(ACT_WR_STATUS);
        ev.status_data = 32'h0000_FF00;
        push_event(ev);
        push_event(gen_event(ACT_INTERRUPT));

        // Random part in four phases, flipping the merge bit between them and
        // draining the unit once in the middle of each phase.
        for (int phase = 0; phase < 4; phase++) begin
            push_control(ITEM_CONFIG, (phase % 2 == 0) ? 1'b1 : 1'b0);
            phase_end = queued_events + PHASE_EVENTS;
            drained   = 1'b0;
            while (queued_events < phase_end) begin
                if (!drained && queued_events >= phase_end - PHASE_EVENTS / 2) begin
                    push_control(ITEM_DRAIN, 1'b0);
                    drained = 1'b1;
                end
                if ($urandom_range(0, 2) == 0) begin
                    // Handler-like round: enable, poll, take the interrupt,
                    // then issue one random action inside the handler.
                    ev = gen_event(ACT_WR_STATUS);
                    ev.status_data[ST_IE]  = 1'b1;
                    ev.status_data[ST_EXL] = 1'b0;
                    ev.status_data[ST_ERL] = 1'b0;
                    push_event(ev);
                    repeat ($urandom_range(1, 3)) push_event(gen_event(ACT_CHECK));
                    push_event(gen_event(ACT_INTERRUPT));
                    push_event(gen_event(rand_action()));
                end else begin
                    push_event(gen_event(rand_action()));
                end
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the sender to run dry and every result to come back.
        while (pending_items.size() != 0 || s_axis_tvalid || i_cfg_valid ||
               expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES * 4) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ mips_exception_entry_unit.f @@
design/mexu_pkg.sv
design/mips_exception_entry_unit.sv
test/testbench.sv
